/* rtl/huffman_tree_bit_decoder_assert.svh */
// Assertion macros for the Huffman tree decoder checker.
// Expects aclk and aresetn in the scope where a macro is used.
`ifndef HUFFMAN_TREE_BIT_DECODER_ASSERT_SVH
`define HUFFMAN_TREE_BIT_DECODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HTBD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HTBD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/htbd_pkg.sv */
// Shared types and constants of the Huffman tree decoder.
// Used by the top level and by its port checker; depends on nothing.
package htbd_pkg;

    localparam int SYM_W      = 8;
    localparam int LEN_W      = 6;
    localparam int CODE_W     = 32;
    localparam int BYTE_W     = 8;
    localparam int REG_W      = 32;
    localparam int STATUS_W   = 3;
    localparam int REQ_W      = 2;
    localparam int APB_ADDR_W = 3;
    localparam int BCNT_W     = $clog2(BYTE_W + 1);

    // Register index, taken from the word address bit of paddr.
    localparam logic REG_TOTAL_SYMBOLS = 1'b0;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_DECODE = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_BAD_LEN = 3'd1,
        ST_WIDE    = 3'd2,
        ST_CLASH   = 3'd3,
        ST_FULL    = 3'd4,
        ST_MISSING = 3'd5
    } status_t;

    typedef struct packed {
        logic             sym_valid;
        logic [SYM_W-1:0] sym;
        status_t          status;
        logic             done;
    } result_t;

endpackage

/* rtl/huffman_tree_bit_decoder.sv */
// Huffman code tree decoder: tree build, bit-serial walk and result output.
// Depends on htbd_pkg.

// A decode word first fetches the current walk node from the node store,
// then takes the bits of the byte in turn (a single registered node-store
// read per tree branch), then hands over the final result word. An insert
// word first shifts off the bits above the code (32 minus the code length,
// when that is positive) to align the code, then checks the path bit by
// bit, builds it bit by bit and hands over its result; a clear or unused
// word goes straight to its result. One word is worked on at a time. The
// root node lives in a register and leaves are folded into their parents'
// branch entries, so no clearing pass runs after reset or clear. Stalls on
// the result side hold the walk in place.
module huffman_tree_bit_decoder #(
    parameter int MAX_CODE_LEN = 32,
    parameter int NODE_SLOTS   = 512
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [htbd_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [htbd_pkg::REG_W-1:0]          pwdata,
    output logic [htbd_pkg::REG_W-1:0]          prdata,
    output logic                                pready,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [htbd_pkg::REQ_W-1:0]          s_req_type,
    input  logic [htbd_pkg::SYM_W-1:0]          s_symbol,
    input  logic [htbd_pkg::LEN_W-1:0]          s_code_length,
    input  logic [htbd_pkg::CODE_W-1:0]         s_code_value,
    input  logic [htbd_pkg::BYTE_W-1:0]         s_data_byte,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_sym_valid,
    output logic [htbd_pkg::SYM_W-1:0]          m_symbol_out,
    output logic                                m_last,
    output htbd_pkg::status_t                   m_status,
    output logic                                m_done_res
);
    import htbd_pkg::*;

    localparam int IDX_W = $clog2(NODE_SLOTS);
    localparam int CNT_W = $clog2(NODE_SLOTS + 1);
    localparam int VAL_W = (IDX_W > SYM_W) ? IDX_W : SYM_W;

    // A branch points either at an inner node or, when leaf is set, holds
    // the symbol of the leaf directly.
    typedef struct packed {
        logic             present;
        logic             leaf;
        logic [VAL_W-1:0] val;
    } branch_t;

    typedef struct packed {
        branch_t [1:0] br;
    } node_t;

    localparam node_t EMPTY_NODE = '0;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_ALIGN   = 7'b0000010,
        S_CHECK   = 7'b0000100,
        S_BUILD   = 7'b0001000,
        S_DEC_BIT = 7'b0010000,
        S_DEC_END = 7'b0100000,
        S_RESP    = 7'b1000000
    } state_t;

    // Control state
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   nodes_used_reg, nodes_used_next;
    logic               walk_root_reg, walk_root_next;
    logic [REG_W-1:0]   count_reg, count_next;
    logic [REG_W-1:0]   total_reg, total_next;
    logic               pend_valid_reg, pend_valid_next;
    logic               m_valid_reg, m_valid_next;
    node_t              root_reg, root_next;

    // Payload state
    logic [SYM_W-1:0]   sym_reg, sym_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [LEN_W-1:0]   rem_reg, rem_next;
    logic [LEN_W-1:0]   pos_reg, pos_next;
    logic [CODE_W-1:0]  code_sr_reg, code_sr_next;
    logic [CODE_W-1:0]  aligned_reg, aligned_next;
    status_t            status_reg, status_next;
    logic               at_root_reg, at_root_next;
    logic               fresh_reg, fresh_next;
    logic [IDX_W-1:0]   cur_reg, cur_next;
    logic [IDX_W-1:0]   walk_idx_reg, walk_idx_next;
    logic [BYTE_W-1:0]  byte_sr_reg, byte_sr_next;
    logic [BCNT_W-1:0]  bits_left_reg, bits_left_next;
    result_t            pend_reg, pend_next;
    result_t            out_reg, out_next;
    logic               out_last_reg, out_last_next;

    // Node store
    node_t              node_mem [NODE_SLOTS];
    node_t              rdata_reg;
    logic               mem_we, mem_re;
    logic [IDX_W-1:0]   mem_waddr, mem_raddr;
    node_t              mem_wdata;

    // Combinational helpers
    logic               out_free;
    logic               push;
    result_t            push_res;
    logic               push_last;
    node_t              cur_node, dec_node, wnode;
    logic               code_bit, last_bit, code_shift, full_now;
    branch_t            cbr, dbr;
    logic [IDX_W-1:0]   new_idx;
    logic [REG_W-1:0]   count_inc;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[APB_ADDR_W-1] == REG_TOTAL_SYMBOLS) ? total_reg : '0;

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_sym_valid  = out_reg.sym_valid;
    assign m_symbol_out = out_reg.sym;
    assign m_status     = out_reg.status;
    assign m_done_res   = out_reg.done;
    assign m_last       = out_last_reg;

    assign out_free  = !m_valid_reg || m_ready;
    assign cur_node  = fresh_reg ? EMPTY_NODE : (at_root_reg ? root_reg : rdata_reg);
    assign dec_node  = walk_root_reg ? root_reg : rdata_reg;
    // Bits of a code longer than the value field are leading zeros.
    assign code_shift = (rem_reg <= LEN_W'(CODE_W));
    assign code_bit  = code_shift ? code_sr_reg[CODE_W-1] : 1'b0;
    assign last_bit  = (rem_reg == LEN_W'(1));
    assign cbr       = cur_node.br[code_bit];
    assign dbr       = dec_node.br[byte_sr_reg[BYTE_W-1]];
    assign new_idx   = nodes_used_reg[IDX_W-1:0];
    assign count_inc = count_reg + REG_W'(1);
    assign full_now  = int'(rem_reg) > (NODE_SLOTS - int'(nodes_used_reg));

    always_comb begin
        state_next      = state_reg;
        nodes_used_next = nodes_used_reg;
        walk_root_next  = walk_root_reg;
        count_next      = count_reg;
        total_next      = total_reg;
        pend_valid_next = pend_valid_reg;
        root_next       = root_reg;
        sym_next        = sym_reg;
        len_next        = len_reg;
        rem_next        = rem_reg;
        pos_next        = pos_reg;
        code_sr_next    = code_sr_reg;
        aligned_next    = aligned_reg;
        status_next     = status_reg;
        at_root_next    = at_root_reg;
        fresh_next      = fresh_reg;
        cur_next        = cur_reg;
        walk_idx_next   = walk_idx_reg;
        byte_sr_next    = byte_sr_reg;
        bits_left_next  = bits_left_reg;
        pend_next       = pend_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = cur_reg;
        mem_raddr       = '0;
        mem_wdata       = cur_node;
        wnode           = cur_node;
        push            = 1'b0;
        push_res        = '{sym_valid: 1'b0, sym: '0, status: status_reg,
                            done: (count_reg >= total_reg)};
        push_last       = 1'b1;

        if (cfg_write && (paddr[APB_ADDR_W-1] == REG_TOTAL_SYMBOLS)) begin
            total_next = pwdata;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    unique case (req_t'(s_req_type))
                        REQ_CLEAR: begin
                            root_next       = EMPTY_NODE;
                            nodes_used_next = CNT_W'(1);
                            walk_root_next  = 1'b1;
                            count_next      = '0;
                            status_next     = ST_OK;
                            state_next      = S_RESP;
                        end
                        REQ_INSERT: begin
                            sym_next     = s_symbol;
                            len_next     = s_code_length;
                            code_sr_next = s_code_value;
                            pos_next     = LEN_W'(CODE_W);
                            if (s_code_length == '0 || int'(s_code_length) > MAX_CODE_LEN) begin
                                status_next = ST_BAD_LEN;
                                state_next  = S_RESP;
                            end else begin
                                state_next = S_ALIGN;
                            end
                        end
                        REQ_DECODE: begin
                            byte_sr_next   = s_data_byte;
                            bits_left_next = BCNT_W'(BYTE_W);
                            // Refetch the walk node: an insert may have changed it.
                            mem_re         = !walk_root_reg;
                            mem_raddr      = walk_idx_reg;
                            state_next     = S_DEC_BIT;
                        end
                        REQ_NONE: begin
                            status_next = ST_OK;
                            state_next  = S_RESP;
                        end
                    endcase
                end
            end

            S_ALIGN: begin
                // Shift the value left until its first code bit is the MSB;
                // any set bit shifted off lies above the code length.
                if (pos_reg > len_reg) begin
                    if (code_sr_reg[CODE_W-1]) begin
                        status_next = ST_WIDE;
                        state_next  = S_RESP;
                    end else begin
                        code_sr_next = code_sr_reg << 1;
                        pos_next     = pos_reg - LEN_W'(1);
                    end
                end else begin
                    aligned_next = code_sr_reg;
                    rem_next     = len_reg;
                    at_root_next = 1'b1;
                    fresh_next   = 1'b0;
                    state_next   = S_CHECK;
                end
            end

            S_CHECK: begin
                priority if (!cbr.present) begin
                    // Path leaves the tree: every remaining bit needs a node.
                    if (full_now) begin
                        status_next = ST_FULL;
                        state_next  = S_RESP;
                    end else begin
                        code_sr_next = aligned_reg;
                        rem_next     = len_reg;
                        at_root_next = 1'b1;
                        state_next   = S_BUILD;
                    end
                end else if (!last_bit) begin
                    if (cbr.leaf) begin
                        status_next = ST_CLASH;
                        state_next  = S_RESP;
                    end else begin
                        mem_re       = 1'b1;
                        mem_raddr    = cbr.val[IDX_W-1:0];
                        at_root_next = 1'b0;
                        rem_next     = rem_reg - LEN_W'(1);
                        if (code_shift) begin
                            code_sr_next = code_sr_reg << 1;
                        end
                    end
                end else begin
                    if (!cbr.leaf) begin
                        status_next = ST_CLASH;
                        state_next  = S_RESP;
                    end else begin
                        code_sr_next = aligned_reg;
                        rem_next     = len_reg;
                        at_root_next = 1'b1;
                        state_next   = S_BUILD;
                    end
                end
            end

            S_BUILD: begin
                if (cbr.present && !last_bit) begin
                    mem_re       = 1'b1;
                    mem_raddr    = cbr.val[IDX_W-1:0];
                    cur_next     = cbr.val[IDX_W-1:0];
                    at_root_next = 1'b0;
                    rem_next     = rem_reg - LEN_W'(1);
                    if (code_shift) begin
                        code_sr_next = code_sr_reg << 1;
                    end
                end else begin
                    if (cbr.present) begin
                        // Same codeword again: only the symbol changes.
                        wnode.br[code_bit].val = VAL_W'(sym_reg);
                    end else begin
                        nodes_used_next = nodes_used_reg + CNT_W'(1);
                        wnode.br[code_bit].present = 1'b1;
                        wnode.br[code_bit].leaf    = last_bit;
                        wnode.br[code_bit].val     = last_bit ? VAL_W'(sym_reg)
                                                              : VAL_W'(new_idx);
                    end
                    if (at_root_reg) begin
                        root_next = wnode;
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = cur_reg;
                        mem_wdata = wnode;
                    end
                    if (last_bit) begin
                        status_next = ST_OK;
                        state_next  = S_RESP;
                    end else begin
                        // The new inner node starts empty and is written
                        // when its own branch is added next cycle.
                        cur_next     = new_idx;
                        fresh_next   = 1'b1;
                        at_root_next = 1'b0;
                        rem_next     = rem_reg - LEN_W'(1);
                        if (code_shift) begin
                            code_sr_next = code_sr_reg << 1;
                        end
                    end
                end
            end

            S_DEC_BIT: begin
                if (count_reg >= total_reg) begin
                    state_next = S_DEC_END;
                end else if (dbr.present && !dbr.leaf) begin
                    mem_re         = 1'b1;
                    mem_raddr      = dbr.val[IDX_W-1:0];
                    walk_idx_next  = dbr.val[IDX_W-1:0];
                    walk_root_next = 1'b0;
                    byte_sr_next   = byte_sr_reg << 1;
                    bits_left_next = bits_left_reg - BCNT_W'(1);
                    if (bits_left_reg == BCNT_W'(1)) begin
                        state_next = S_DEC_END;
                    end
                end else if (!pend_valid_reg || out_free) begin
                    // A result is held back one step so that the last one
                    // of the byte can be marked.
                    if (pend_valid_reg) begin
                        push      = 1'b1;
                        push_res  = pend_reg;
                        push_last = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    if (dbr.present) begin
                        count_next = count_inc;
                        pend_next  = '{sym_valid: 1'b1, sym: dbr.val[SYM_W-1:0],
                                       status: ST_OK, done: (count_inc >= total_reg)};
                    end else begin
                        pend_next  = '{sym_valid: 1'b0, sym: '0,
                                       status: ST_MISSING, done: (count_reg >= total_reg)};
                    end
                    walk_root_next = 1'b1;
                    byte_sr_next   = byte_sr_reg << 1;
                    bits_left_next = bits_left_reg - BCNT_W'(1);
                    if (bits_left_reg == BCNT_W'(1)) begin
                        state_next = S_DEC_END;
                    end
                end
            end

            S_DEC_END: begin
                if (out_free) begin
                    push = 1'b1;
                    if (pend_valid_reg) begin
                        push_res = pend_reg;
                    end else begin
                        push_res = '{sym_valid: 1'b0, sym: '0, status: ST_OK,
                                     done: (count_reg >= total_reg)};
                    end
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            S_RESP: begin
                if (out_free) begin
                    push       = 1'b1;
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        m_valid_next  = m_valid_reg;
        out_next      = out_reg;
        out_last_next = out_last_reg;
        if (push) begin
            m_valid_next  = 1'b1;
            out_next      = push_res;
            out_last_next = push_last;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            nodes_used_reg <= CNT_W'(1);
            walk_root_reg  <= 1'b1;
            count_reg      <= '0;
            total_reg      <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            root_reg       <= EMPTY_NODE;
        end else begin
            state_reg      <= state_next;
            nodes_used_reg <= nodes_used_next;
            walk_root_reg  <= walk_root_next;
            count_reg      <= count_next;
            total_reg      <= total_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            root_reg       <= root_next;
        end
    end

    always_ff @(posedge aclk) begin
        sym_reg       <= sym_next;
        len_reg       <= len_next;
        rem_reg       <= rem_next;
        pos_reg       <= pos_next;
        code_sr_reg   <= code_sr_next;
        aligned_reg   <= aligned_next;
        status_reg    <= status_next;
        at_root_reg   <= at_root_next;
        fresh_reg     <= fresh_next;
        cur_reg       <= cur_next;
        walk_idx_reg  <= walk_idx_next;
        byte_sr_reg   <= byte_sr_next;
        bits_left_reg <= bits_left_next;
        pend_reg      <= pend_next;
        out_reg       <= out_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            node_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= node_mem[mem_raddr];
        end
    end

endmodule

/* rtl/htbd_checker.sv */
// Port-level checks of the Huffman tree decoder, bound to its top level.
// Depends on htbd_pkg and the assertion macro header.
`include "huffman_tree_bit_decoder_assert.svh"

module htbd_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic                        m_sym_valid,
    input logic [htbd_pkg::SYM_W-1:0]  m_symbol_out,
    input logic                        m_last,
    input htbd_pkg::status_t           m_status,
    input logic                        m_done_res
);
    import htbd_pkg::*;

    // A stalled result word keeps its contents.
    `HTBD_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable({m_sym_valid, m_symbol_out, m_last, m_status, m_done_res}), "result word changed while stalled")

    // Words are worked on one at a time.
    `HTBD_ASSERT_NEXT(a_one_word, s_valid && s_ready, !s_ready, "input taken while a word is in work")

    // While a word still has results to come, no new word is taken.
    `HTBD_ASSERT_NOW(a_no_take_mid, m_valid && !m_last, !s_ready, "input taken before the last result")

    // Insert failures come as a single result without a symbol.
    `HTBD_ASSERT_NOW(a_insert_err, m_valid && (m_status == ST_BAD_LEN || m_status == ST_WIDE || m_status == ST_CLASH || m_status == ST_FULL), m_last && !m_sym_valid, "insert error not a lone result")

endmodule

bind huffman_tree_bit_decoder htbd_checker u_htbd_checker (.*);
